// ===== hdl/ttd_pkg.sv =====
`default_nettype none
package ttd_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 15;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned MAX_RESULTS       = 3;

  localparam logic [7:0] NL = 8'h0A;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_WORD_MODE = 1'b1;

  localparam logic DIR_TOKENIZE   = 1'b0;
  localparam logic DIR_DETOKENIZE = 1'b1;

  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } job_t;

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/text_tokenizer_detokenizer_top.sv =====
// Byte-stream tokenizer / detokenizer. Each input word is one byte or an
// end-of-stream marker; it produces zero to three output bytes, the last one
// flagged by out_last_of_run. The front end classifies each word and updates
// the word-length and line-phase state in the cycle it is accepted, so it
// takes one input word per cycle while the two-entry job queue has room.
// The back end sends one output byte per cycle while out_ready is high, so
// the sustained rate is set by the output side and by how many bytes each
// input word emits (at most three); words that emit nothing only need to
// be accepted. Registers: index 0 direction (0 tokenize,
// 1 detokenize), index 1 word mode; write them only while the block is idle.
`default_nettype none
module text_tokenizer_detokenizer_top #(
  parameter int unsigned MAX_TOKEN_LEN = ttd_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic         cfg_wdata,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_end_marker,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_of_run
);
  import ttd_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  job_t push_job, head_job;

  ttd_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_end_marker (in_end_marker),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  ttd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  ttd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (head_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

// ===== hdl/ttd_front.sv =====
`default_nettype none
module ttd_front #(
  parameter int unsigned MAX_TOKEN_LEN = ttd_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic         cfg_wdata,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_end_marker,
  input  wire logic         q_full,
  output logic              q_push,
  output ttd_pkg::job_t     q_job
);
  import ttd_pkg::*;

  localparam int unsigned WL_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [WL_W-1:0] WL_MAX = WL_W'(MAX_TOKEN_LEN);

  typedef enum logic [1:0] {
    PH_LINE_START = 2'd0,
    PH_IN_LINE    = 2'd1,
    PH_ESCAPE     = 2'd2,
    PH_DROP       = 2'd3
  } phase_t;

  logic            direction_r;
  logic            word_mode_r;
  logic [WL_W-1:0] word_len_r, word_len_nxt;
  phase_t          phase_r, phase_nxt;
  job_t            job;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (job.cnt != 2'd0);
  assign q_job    = job;

  always_comb begin
    job          = '0;
    word_len_nxt = word_len_r;
    phase_nxt    = phase_r;
    if (in_end_marker) begin
      if (direction_r == DIR_TOKENIZE && word_len_r != '0) begin
        job.cnt      = 2'd1;
        job.bytes[0] = NL;
      end
      word_len_nxt = '0;
      phase_nxt    = PH_LINE_START;
    end else if (direction_r == DIR_TOKENIZE) begin
      if (!word_mode_r) begin
        job.cnt      = 2'd2;
        job.bytes[0] = in_byte;
        job.bytes[1] = NL;
      end else if (is_letter(in_byte)) begin
        if (word_len_r >= WL_MAX) begin
          job.cnt      = 2'd2;
          job.bytes[0] = NL;
          job.bytes[1] = in_byte;
          word_len_nxt = WL_W'(1);
        end else begin
          job.cnt      = 2'd1;
          job.bytes[0] = in_byte;
          word_len_nxt = word_len_r + WL_W'(1);
        end
      end else begin
        if (word_len_r != '0) begin
          job.cnt      = 2'd3;
          job.bytes[0] = NL;
          job.bytes[1] = in_byte;
          job.bytes[2] = NL;
        end else begin
          job.cnt      = 2'd2;
          job.bytes[0] = in_byte;
          job.bytes[1] = NL;
        end
        word_len_nxt = '0;
      end
    end else begin
      job.bytes[0] = in_byte;
      case (phase_r)
        PH_LINE_START: begin
          if (in_byte == NL) begin
            phase_nxt = PH_ESCAPE;
          end else begin
            job.cnt   = 2'd1;
            phase_nxt = word_mode_r ? PH_IN_LINE : PH_DROP;
          end
        end
        PH_IN_LINE: begin
          if (in_byte == NL) begin
            phase_nxt = PH_LINE_START;
          end else begin
            job.cnt = 2'd1;
          end
        end
        PH_ESCAPE: begin
          job.cnt   = 2'd1;
          phase_nxt = (in_byte == NL) ? PH_LINE_START : PH_DROP;
        end
        default: begin
          if (in_byte == NL) begin
            phase_nxt = PH_LINE_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_TOKENIZE;
      word_mode_r <= 1'b1;
      word_len_r  <= '0;
      phase_r     <= PH_LINE_START;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION: direction_r <= cfg_wdata;
          CFG_WORD_MODE: word_mode_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        word_len_r <= word_len_nxt;
        phase_r    <= phase_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ttd_queue.sv =====
`default_nettype none
module ttd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  ttd_pkg::job_t       push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output ttd_pkg::job_t       head_job
);
  import ttd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = slots_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ttd_back.sv =====
`default_nettype none
module ttd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  ttd_pkg::job_t       q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last_of_run
);
  import ttd_pkg::*;

  job_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       last;

  assign last            = (idx_r == cur_r.cnt - 2'd1);
  assign out_valid       = cur_valid_r;
  assign out_byte        = cur_r.bytes[idx_r];
  assign out_last_of_run = last;
  assign q_pop           = !q_empty && (!cur_valid_r || (out_ready && last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (cur_valid_r && out_ready) begin
        if (last) begin
          cur_valid_r <= 1'b0;
          idx_r       <= '0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire
